[rtl/pcf_pkg.sv]
package pcf_pkg;

  localparam int unsigned LenW  = 31;
  localparam int unsigned TypeW = 32;
  localparam int unsigned CrcW  = 32;
  localparam int unsigned PhW   = 4;

  localparam logic [CrcW-1:0] CrcPoly   = 32'hEDB8_8320;
  localparam logic [CrcW-1:0] CrcPreset = 32'hFFFF_FFFF;

  // configuration register indexes
  localparam logic REG_PAYLOAD_LENGTH = 1'b0;
  localparam logic REG_CHUNK_TYPE     = 1'b1;

  // burst phases of one item
  localparam logic [PhW-1:0] PH_LEN0  = 4'd0;
  localparam logic [PhW-1:0] PH_LEN3  = 4'd3;
  localparam logic [PhW-1:0] PH_TYPE0 = 4'd4;
  localparam logic [PhW-1:0] PH_TYPE3 = 4'd7;
  localparam logic [PhW-1:0] PH_DATA  = 4'd8;
  localparam logic [PhW-1:0] PH_CRC0  = 4'd9;
  localparam logic [PhW-1:0] PH_CRC3  = 4'd12;

  typedef struct packed {
    logic [LenW-1:0]  payload_length;
    logic [TypeW-1:0] chunk_type;
  } cfg_t;

  typedef logic [CrcW-1:0] crc_tab_t [256];

  function automatic crc_tab_t crc_tab_build();
    crc_tab_t t;
    logic [CrcW-1:0] v;
    for (int i = 0; i < 256; i++) begin
      v = CrcW'(i);
      for (int k = 0; k < 8; k++) begin
        v = v[0] ? (CrcPoly ^ (v >> 1)) : (v >> 1);
      end
      t[i] = v;
    end
    return t;
  endfunction

  localparam crc_tab_t CRC_TABLE = crc_tab_build();

  function automatic logic [CrcW-1:0] crc_fold(logic [CrcW-1:0] c, logic [7:0] b);
    return CRC_TABLE[c[7:0] ^ b] ^ {8'h00, c[CrcW-1:8]};
  endfunction

  // byte i of a big-endian word, i = 0 is the top byte
  function automatic logic [7:0] be_byte(logic [31:0] w, logic [1:0] i);
    return w[{~i, 3'b000} +: 8];
  endfunction

endpackage

[rtl/pcf_cfg.sv]
module pcf_cfg (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic          cfg_idx_i,
  input  logic [31:0]   cfg_wdata_i,
  output pcf_pkg::cfg_t cfg_o
);
  import pcf_pkg::*;

  logic [LenW-1:0]  len_q, len_d;
  logic [TypeW-1:0] type_q, type_d;

  always_comb begin
    len_d  = len_q;
    type_d = type_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_PAYLOAD_LENGTH: len_d  = cfg_wdata_i[LenW-1:0];
        REG_CHUNK_TYPE:     type_d = cfg_wdata_i[TypeW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q  <= LenW'(1);
      type_q <= '0;
    end else begin
      len_q  <= len_d;
      type_q <= type_d;
    end
  end

  assign cfg_o.payload_length = len_q;
  assign cfg_o.chunk_type     = type_q;

endmodule

[rtl/pcf_core.sv]
module pcf_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  pcf_pkg::cfg_t cfg_i,
  input  logic          item_valid_i,
  input  logic [7:0]    item_byte_i,
  output logic          item_done_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output logic [7:0]    out_byte_o,
  output logic          run_end_o,
  output logic          chunk_end_o
);
  import pcf_pkg::*;

  logic [PhW-1:0]  phase_q, phase_d;
  logic [CrcW-1:0] crc_q, crc_d;
  logic [LenW-1:0] seen_q, seen_d;
  logic            out_valid_q, out_valid_d;
  logic [7:0]      out_byte_q, out_byte_d;
  logic            run_end_q, run_end_d;
  logic            chunk_end_q, chunk_end_d;

  logic            step;
  logic            done;
  logic [LenW-1:0] len;
  logic [LenW-1:0] seen_inc;
  logic [7:0]      type_byte;
  logic [1:0]      crc_idx;

  // zero length behaves as one
  assign len      = (cfg_i.payload_length == '0) ? LenW'(1) : cfg_i.payload_length;
  assign seen_inc = seen_q + LenW'(1);
  assign type_byte = be_byte(cfg_i.chunk_type, phase_q[1:0]);
  assign crc_idx  = 2'(phase_q - PH_CRC0);

  assign step = item_valid_i && (!out_valid_q || !out_stall_i);

  always_comb begin
    phase_d     = phase_q;
    crc_d       = crc_q;
    seen_d      = seen_q;
    out_byte_d  = out_byte_q;
    run_end_d   = 1'b0;
    chunk_end_d = 1'b0;
    done        = 1'b0;
    unique case (phase_q) inside
      [PH_LEN0:PH_LEN3]: begin
        out_byte_d = be_byte({1'b0, len}, phase_q[1:0]);
        phase_d    = phase_q + PhW'(1);
      end
      [PH_TYPE0:PH_TYPE3]: begin
        out_byte_d = type_byte;
        // a new chunk always starts from the preset
        crc_d      = crc_fold((phase_q == PH_TYPE0) ? CrcPreset : crc_q, type_byte);
        phase_d    = phase_q + PhW'(1);
      end
      PH_DATA: begin
        out_byte_d = item_byte_i;
        crc_d      = crc_fold(crc_q, item_byte_i);
        if (seen_inc >= len) begin
          seen_d  = '0;
          phase_d = PH_CRC0;
        end else begin
          seen_d    = seen_inc;
          run_end_d = 1'b1;
          done      = 1'b1;
          // count wrapped: next word opens a new header
          phase_d   = (seen_inc == '0) ? PH_LEN0 : PH_DATA;
        end
      end
      [PH_CRC0:PH_CRC3]: begin
        out_byte_d = be_byte(~crc_q, crc_idx);
        if (phase_q == PH_CRC3) begin
          run_end_d   = 1'b1;
          chunk_end_d = 1'b1;
          done        = 1'b1;
          crc_d       = CrcPreset;
          phase_d     = PH_LEN0;
        end else begin
          phase_d = phase_q + PhW'(1);
        end
      end
      default: phase_d = PH_LEN0;
    endcase
  end

  always_comb begin
    if (step) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_LEN0;
      crc_q       <= CrcPreset;
      seen_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (step) begin
        phase_q <= phase_d;
        crc_q   <= crc_d;
        seen_q  <= seen_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_byte_q  <= out_byte_d;
      run_end_q   <= run_end_d;
      chunk_end_q <= chunk_end_d;
    end
  end

  assign item_done_o = step && done;
  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign run_end_o   = run_end_q;
  assign chunk_end_o = chunk_end_q;

endmodule

[rtl/png_chunk_framer_crc32.sv]
// channel   dir  handshake               payload
// input     in   in_valid_i/in_stall_o    payload_byte_i
// output    out  out_valid_o/out_stall_i  out_byte_o, run_end_o, chunk_end_o
// config    in   cfg_we_i                 cfg_idx_i, cfg_wdata_i
//
// a word opening a chunk sends 9 bytes (13 if it also ends the chunk), a
// mid-chunk word 1 byte, the last word 5 bytes, through the one-byte-wide
// output register; crc folds one byte per cycle through the table, unless the
// output stalls, while the type and data bytes go out.
// a word is held in an input register while its bytes are sent, so the next
// word is taken in the cycle its last byte is loaded into the output register.
// reset clears the crc to all ones, the count and the burst phase.
module png_chunk_framer_crc32 (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  payload_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_byte_o,
  output logic        run_end_o,
  output logic        chunk_end_o
);
  import pcf_pkg::*;

  cfg_t       cfg;
  logic       in_valid_q, in_valid_d;
  logic [7:0] in_byte_q;
  logic       accept;
  logic       item_done;

  pcf_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cfg_o      (cfg)
  );

  assign in_stall_o = in_valid_q && !item_done;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    if (accept) begin
      in_valid_d = 1'b1;
    end else if (item_done) begin
      in_valid_d = 1'b0;
    end else begin
      in_valid_d = in_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_byte_q <= payload_byte_i;
    end
  end

  pcf_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .item_valid_i(in_valid_q),
    .item_byte_i (in_byte_q),
    .item_done_o (item_done),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_byte_o  (out_byte_o),
    .run_end_o   (run_end_o),
    .chunk_end_o (chunk_end_o)
  );

endmodule

[rtl/pcf_chk.sv]
module pcf_chk (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] out_byte_o,
  input logic       run_end_o,
  input logic       chunk_end_o
);

  // a stalled output word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_byte_o)
      && $stable(run_end_o) && $stable(chunk_end_o))
    else $error("stalled output word changed");

  // the last crc byte also closes the run of its input word
  a_chunk_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && chunk_end_o |-> run_end_o)
    else $error("chunk end without run end");

  // inside a burst the next byte follows at once
  a_burst_gapless: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !run_end_o |=> out_valid_o)
    else $error("gap inside output burst");

  // no input taken while a burst is half sent and stalled
  a_hold_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i && !run_end_o |-> in_stall_o)
    else $error("input taken mid burst");

endmodule

bind png_chunk_framer_crc32 pcf_chk u_chk (.*);

[tb/tb.sv]
module tb;
  import pcf_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int HOLD_CYCLES  = 320;
  localparam int DRAIN_CYCLES = 16;
  localparam int RAND_ITEMS   = 210;

  typedef struct packed {
    logic [7:0] data;
    logic       run_end;
    logic       chunk_end;
  } framed_byte_t;

  typedef enum logic [1:0] {ROW_LEN, ROW_TYPE, ROW_BYTE} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [31:0] val;
    logic        hdr;
    logic [31:0] hdr_len;
    logic [31:0] hdr_type;
  } row_t;

  typedef enum logic [1:0] {RX_FREE, RX_LIGHT, RX_HEAVY, RX_TOGGLE} rx_mode_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic        cfg_idx;
  logic [31:0] cfg_wdata;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  payload;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  out_byte;
  logic        run_end;
  logic        chunk_end;

  png_chunk_framer_crc32 uut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .payload_byte_i (payload),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .out_byte_o     (out_byte),
    .run_end_o      (run_end),
    .chunk_end_o    (chunk_end)
  );

  // predictor state
  logic [31:0]  crc_lut [256];
  logic [30:0]  model_len;
  logic [31:0]  model_type;
  logic [31:0]  model_crc;
  logic [30:0]  model_count;
  framed_byte_t framed_q [$];

  framed_byte_t want;
  int           word_count = 0;
  int           fault_count = 0;
  int           cycle_count = 0;
  int           burst_left;
  bit           hold_off_req = 1'b0;

  row_t steps [24] = '{
    '{ROW_BYTE, 32'h0000_0000, 1'b1, 32'd1,         32'h0000_0000},
    '{ROW_TYPE, 32'h4948_4452, 1'b0, 32'd0,         32'd0},
    '{ROW_LEN,  32'h0000_0000, 1'b0, 32'd0,         32'd0},
    '{ROW_BYTE, 32'h0000_00ff, 1'b1, 32'd1,         32'h4948_4452},
    '{ROW_LEN,  32'hffff_ffff, 1'b0, 32'd0,         32'd0},
    '{ROW_TYPE, 32'hffff_ffff, 1'b0, 32'd0,         32'd0},
    '{ROW_BYTE, 32'h0000_0080, 1'b1, 32'h7fff_ffff, 32'hffff_ffff},
    '{ROW_BYTE, 32'h0000_007f, 1'b0, 32'd0,         32'd0},
    '{ROW_TYPE, 32'h4944_4154, 1'b0, 32'd0,         32'd0},
    '{ROW_LEN,  32'h0000_0001, 1'b0, 32'd0,         32'd0},
    '{ROW_BYTE, 32'h0000_0055, 1'b0, 32'd0,         32'd0},
    '{ROW_LEN,  32'h0000_0003, 1'b0, 32'd0,         32'd0},
    '{ROW_BYTE, 32'h0000_0001, 1'b1, 32'd3,         32'h4944_4154},
    '{ROW_BYTE, 32'h0000_0002, 1'b0, 32'd0,         32'd0},
    '{ROW_BYTE, 32'h0000_0003, 1'b0, 32'd0,         32'd0},
    '{ROW_TYPE, 32'h0000_0000, 1'b0, 32'd0,         32'd0},
    '{ROW_LEN,  32'h0000_0002, 1'b0, 32'd0,         32'd0},
    '{ROW_BYTE, 32'h0000_00aa, 1'b1, 32'd2,         32'h0000_0000},
    '{ROW_BYTE, 32'h0000_0055, 1'b0, 32'd0,         32'd0},
    '{ROW_LEN,  32'h0000_0004, 1'b0, 32'd0,         32'd0},
    '{ROW_BYTE, 32'h0000_0000, 1'b1, 32'd4,         32'h0000_0000},
    '{ROW_BYTE, 32'h0000_00ff, 1'b0, 32'd0,         32'd0},
    '{ROW_BYTE, 32'h0000_0001, 1'b0, 32'd0,         32'd0},
    '{ROW_BYTE, 32'h0000_00fe, 1'b0, 32'd0,         32'd0}
  };

  always #6 clk = ~clk;

  function automatic logic [31:0] crc_step(logic [31:0] c, logic [7:0] b);
    return crc_lut[c[7:0] ^ b] ^ (c >> 8);
  endfunction

  function automatic void push_word(logic [31:0] w, logic ce);
    for (int i = 3; i >= 0; i--) begin
      framed_q.push_back('{w[8*i +: 8], 1'b0, (i == 0) ? ce : 1'b0});
    end
  endfunction

  // header on the opening word, crc after the closing one
  function automatic void frame_payload_byte(logic [7:0] b);
    logic [30:0] eff;
    eff = (model_len == '0) ? 31'd1 : model_len;
    if (model_count == '0) begin
      push_word({1'b0, eff}, 1'b0);
      push_word(model_type, 1'b0);
      model_crc = '1;
      for (int s = 3; s >= 0; s--) begin
        model_crc = crc_step(model_crc, model_type[8*s +: 8]);
      end
    end
    framed_q.push_back('{b, 1'b0, 1'b0});
    model_crc   = crc_step(model_crc, b);
    model_count = model_count + 31'd1;
    if (model_count >= eff) begin
      push_word(~model_crc, 1'b1);
      model_crc   = '1;
      model_count = '0;
    end
    framed_q[framed_q.size() - 1].run_end = 1'b1;
  endfunction

  task automatic write_reg(input logic idx, input logic [31:0] wd);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= wd;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_PAYLOAD_LENGTH) model_len = wd[30:0];
    else model_type = wd;
  endtask

  task automatic send_byte(input logic [7:0] b, output int head_idx);
    @(negedge clk);
    in_valid <= 1'b1;
    payload  <= b;
    do @(posedge clk); while (in_stall);
    head_idx = framed_q.size();
    frame_payload_byte(b);
  endtask

  task automatic offer_byte(input logic [7:0] b);
    int head_idx;
    if (burst_left == 0) begin
      repeat ($urandom_range(1, 6)) @(negedge clk) in_valid <= 1'b0;
      burst_left = ($urandom_range(0, 7) == 0) ? 48 : $urandom_range(1, 12);
    end
    burst_left--;
    send_byte(b, head_idx);
  endtask

  task automatic drain_results();
    @(negedge clk) in_valid <= 1'b0;
    while (framed_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (framed_q.size() == 0) begin
        fault_count++;
        if (fault_count <= 10)
          $display("word %0d: unexpected output %h run_end %b chunk_end %b",
                   word_count, out_byte, run_end, chunk_end);
      end else begin
        want = framed_q.pop_front();
        if (out_byte !== want.data || run_end !== want.run_end
            || chunk_end !== want.chunk_end) begin
          fault_count++;
          if (fault_count <= 10)
            $display("word %0d: expected %h/%b/%b got %h/%b/%b", word_count,
                     want.data, want.run_end, want.chunk_end,
                     out_byte, run_end, chunk_end);
        end
      end
      word_count++;
    end
  end

  // receiver: stall pattern changes every so often, long hold-off on request
  initial begin : rx_stall
    rx_mode_t mode;
    int       span;
    bit       hold_done;
    hold_done = 1'b0;
    out_stall = 1'b0;
    wait (rst_n);
    forever begin
      if (hold_off_req && !hold_done) begin
        @(negedge clk) out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
      end else begin
        mode = rx_mode_t'($urandom_range(0, 3));
        span = $urandom_range(10, 150);
        for (int c = 0; c < span && !(hold_off_req && !hold_done); c++) begin
          @(negedge clk);
          case (mode)
            RX_FREE:  out_stall <= 1'b0;
            RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
            RX_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
            default:  out_stall <= ~out_stall;
          endcase
        end
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < LIMIT_CYCLES) @(posedge clk) cycle_count++;
    $display("Test completed with failures");
    $finish;
  end

  initial begin : stimulus
    int          head_idx;
    int          sent;
    int          phase;
    int          pick;
    int          count;
    logic [30:0] new_len;
    logic [30:0] eff;
    logic [31:0] wd;
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_idx      = REG_PAYLOAD_LENGTH;
    cfg_wdata    = '0;
    in_valid     = 1'b0;
    payload      = '0;
    burst_left   = 0;
    for (int i = 0; i < 256; i++) begin
      wd = 32'(i);
      repeat (8) wd = wd[0] ? ((wd >> 1) ^ 32'hedb8_8320) : (wd >> 1);
      crc_lut[i] = wd;
    end
    model_len   = 31'd1;
    model_type  = '0;
    model_crc   = '1;
    model_count = '0;
    repeat (11) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;

    for (int r = 0; r < 24; r++) begin
      case (steps[r].kind)
        ROW_LEN: begin
          drain_results();
          write_reg(REG_PAYLOAD_LENGTH, steps[r].val);
        end
        ROW_TYPE: begin
          drain_results();
          write_reg(REG_CHUNK_TYPE, steps[r].val);
        end
        default: begin
          send_byte(steps[r].val[7:0], head_idx);
          // header bytes typed in for rows that open a chunk
          if (steps[r].hdr) begin
            for (int k = 0; k < 4; k++) begin
              framed_q[head_idx + k].data     = steps[r].hdr_len[8*(3-k) +: 8];
              framed_q[head_idx + 4 + k].data = steps[r].hdr_type[8*(3-k) +: 8];
            end
          end
        end
      endcase
    end

    sent  = 0;
    phase = 0;
    while (sent < RAND_ITEMS) begin
      drain_results();
      phase++;
      pick = $urandom_range(0, 19);
      if (pick == 0) new_len = '0;
      else if (pick == 1) new_len = 31'($urandom) | 31'h4000_0000;
      else new_len = 31'($urandom_range(1, 12));
      if ($urandom_range(0, 3) != 0) begin
        wd = {1'($urandom_range(0, 1)), new_len};
        write_reg(REG_PAYLOAD_LENGTH, wd);
      end
      if ($urandom_range(0, 3) == 0) begin
        case ($urandom_range(0, 4))
          0:       wd = 32'h4944_4154;
          1:       wd = 32'h7445_5874;
          2:       wd = 32'h504c_5445;
          3:       wd = 32'h4945_4e44;
          default: wd = $urandom;
        endcase
        write_reg(REG_CHUNK_TYPE, wd);
      end
      eff = (model_len == '0) ? 31'd1 : model_len;
      if (phase == 6) begin
        // receiver holds off while the sender keeps offering
        hold_off_req = 1'b1;
        count = 14;
      end else if (eff > 31'd16 || $urandom_range(0, 3) == 0) begin
        count = $urandom_range(1, 6);
      end else begin
        count = (model_count < eff) ? int'(eff - model_count) : 1;
        count += int'(eff) * $urandom_range(0, 2);
      end
      repeat (count) begin
        offer_byte(8'($urandom));
        sent++;
      end
    end

    drain_results();
    if (fault_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule

[filelist.f]
rtl/pcf_pkg.sv
rtl/pcf_cfg.sv
rtl/pcf_core.sv
rtl/png_chunk_framer_crc32.sv
rtl/pcf_chk.sv
tb/tb.sv
